// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the calendar block.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define EPC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("lbl failed");
`define EPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl failed");
`else
`define EPC_ASSERT(lbl, clk, rst, prop)
`define EPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/epc_pkg.sv =====
// Types, constants and calendar helper functions of the calendar block.
// Depends on nothing; used by every module of the block.
package epc_pkg;

   localparam logic [31:0] SecsPerHour = 32'd3600;
   localparam logic [5:0]  DivSixty    = 6'd60;
   localparam logic [5:0]  DivHours    = 6'd24;
   localparam logic [5:0]  DivWeek     = 6'd7;
   localparam logic [15:0] EpochWday   = 16'd4;
   localparam logic [7:0]  YoffNoLeap  = 8'd130;
   localparam logic [3:0]  LastMonth   = 4'd11;

   localparam logic        CsrZoneHours    = 1'b0;
   localparam logic        CsrSummerEnable = 1'b1;

   // Rounded-up reciprocals 2^35/15, 2^33/3 and 2^32/7.
   localparam logic [31:0] RecipFifteen = 32'h8888_8889;
   localparam logic [31:0] RecipThree   = 32'hAAAA_AAAB;
   localparam logic [31:0] RecipSeven   = 32'h2492_4925;

   localparam logic [4:0] MonthLen [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_W_SEC,
      ST_W_MIN,
      ST_W_HOUR,
      ST_W_WDAY,
      ST_YEAR,
      ST_MONTH,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [4:0] zone_hours;
      logic       summer_enable;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [5:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [5:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [31:0] local_seconds;
      logic [5:0]  second_of_minute;
      logic [5:0]  minute_of_hour;
      logic [4:0]  hour_of_day;
      logic [2:0]  weekday;
      logic [7:0]  years_since_1970;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
      logic        summer_applied;
   } cal_type;

   // Within 1970..2106 the only multiple of four that is not a leap year is 2100.
   function automatic logic is_leap(input logic [7:0] yoff);
      return (yoff[1:0] == 2'd2) && (yoff != YoffNoLeap);
   endfunction

   function automatic logic [8:0] year_len(input logic [7:0] yoff);
      return is_leap(yoff) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic [7:0] yoff);
      logic [4:0] len;
      len = MonthLen[m];
      if ((m == 4'd1) && is_leap(yoff)) begin
         len = 5'd29;
      end
      return len;
   endfunction

endpackage

// ===== hdl/epc_div.sv =====
// Shared divider of a 32-bit dividend by 60, 24 or 7, done by reciprocal multiplication
// in mul, fix and done stages. Depends on epc_pkg for the request and response structs.
module epc_div
   import epc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        mul_ff, mul_in;
   logic        fix_ff, fix_in;
   logic        done_ff, done_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [5:0]  dsr_ff, dsr_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  rem_ff, rem_in;
   logic [31:0] scaled;
   logic [31:0] magic;
   logic [63:0] product;
   logic [31:0] quo_calc;
   logic [11:0] back_prod;

   // Sixty and twenty-four first drop their factors of four and eight, so that
   // their reciprocals are exact over the whole dividend range.
   always_comb begin
      unique case (dsr_ff)
         DivSixty: begin
            scaled = {2'd0, dvd_ff[31:2]};
            magic  = RecipFifteen;
         end
         DivHours: begin
            scaled = {3'd0, dvd_ff[31:3]};
            magic  = RecipThree;
         end
         default: begin
            scaled = dvd_ff;
            magic  = RecipSeven;
         end
      endcase
   end

   assign product = {32'd0, scaled} * {32'd0, magic};

   always_comb begin
      unique case (dsr_ff)
         DivSixty: quo_calc = {3'd0, product[63:35]};
         DivHours: quo_calc = {1'b0, product[63:33]};
         default:  quo_calc = product[63:32];
      endcase
   end

   // The remainder is below 64, so the low six bits of quotient times divisor suffice.
   assign back_prod = {6'd0, quo_ff[5:0]} * {6'd0, dsr_ff};

   always_comb begin
      mul_in  = req.start;
      fix_in  = mul_ff;
      done_in = fix_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         dvd_in = req.dividend;
         dsr_in = req.divisor;
      end
      if (mul_ff) begin
         quo_in = quo_calc;
      end
      if (fix_ff) begin
         rem_in = dvd_ff[5:0] - back_prod[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== hdl/epc_core.sv =====
// Sequencer that breaks a local timestamp into calendar fields with the shared divider,
// a year walk and a month walk. Depends on epc_pkg and epc_div.
module epc_core
   import epc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        go,
   input  logic [31:0] epoch_seconds,
   output logic        busy,
   output logic        done,
   output cal_type     cal
);

   state_type   state_ff, state_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0] ts_ff, ts_in;
   logic [31:0] zone_secs;
   logic        applied_ff, applied_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [2:0]  wday_ff, wday_in;
   logic [15:0] days_ff, days_in;
   logic [7:0]  yoff_ff, yoff_in;
   logic [3:0]  mon_ff, mon_in;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic        summer_rule;

   epc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sign-extended zone times 3600 wraps modulo 2^32 like the signed offset.
   assign zone_secs = {{27{cfg.zone_hours[4]}}, cfg.zone_hours} * SecsPerHour;
   assign ylen      = year_len(yoff_ff);
   assign mlen      = month_len(mon_ff, yoff_ff);

   // April..September, late March or early October, with the month still zero based.
   assign summer_rule = ((mon_ff >= 4'd3) && (mon_ff <= 4'd8)) ||
                        ((mon_ff == 4'd2) && (days_ff >= 16'd25)) ||
                        ((mon_ff == 4'd9) && (days_ff < 16'd24));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ts_ff      <= ts_in;
      applied_ff <= applied_in;
      sec_ff     <= sec_in;
      min_ff     <= min_in;
      hour_ff    <= hour_in;
      wday_ff    <= wday_in;
      days_ff    <= days_in;
      yoff_ff    <= yoff_in;
      mon_ff     <= mon_in;
   end

   always_comb begin
      state_in         = state_ff;
      ts_in            = ts_ff;
      applied_in       = applied_ff;
      sec_in           = sec_ff;
      min_in           = min_ff;
      hour_in          = hour_ff;
      wday_in          = wday_ff;
      days_in          = days_ff;
      yoff_in          = yoff_ff;
      mon_in           = mon_ff;
      div_req.start    = 1'b0;
      div_req.dividend = div_rsp.quotient;
      div_req.divisor  = DivSixty;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               ts_in      = epoch_seconds + zone_secs;
               applied_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            div_req.start    = 1'b1;
            div_req.dividend = ts_ff;
            div_req.divisor  = DivSixty;
            state_in         = ST_W_SEC;
         end
         ST_W_SEC: begin
            if (div_rsp.done) begin
               sec_in          = div_rsp.remainder;
               div_req.start   = 1'b1;
               div_req.divisor = DivSixty;
               state_in        = ST_W_MIN;
            end
         end
         ST_W_MIN: begin
            if (div_rsp.done) begin
               min_in          = div_rsp.remainder;
               div_req.start   = 1'b1;
               div_req.divisor = DivHours;
               state_in        = ST_W_HOUR;
            end
         end
         ST_W_HOUR: begin
            if (div_rsp.done) begin
               hour_in          = div_rsp.remainder[4:0];
               days_in          = div_rsp.quotient[15:0];
               div_req.start    = 1'b1;
               div_req.dividend = {16'd0, div_rsp.quotient[15:0] + EpochWday};
               div_req.divisor  = DivWeek;
               state_in         = ST_W_WDAY;
            end
         end
         ST_W_WDAY: begin
            if (div_rsp.done) begin
               wday_in  = div_rsp.remainder[2:0] + 3'd1;
               yoff_in  = 8'd0;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if ({7'd0, ylen} > days_ff) begin
               mon_in   = 4'd0;
               state_in = ST_MONTH;
            end else begin
               days_in = days_ff - {7'd0, ylen};
               yoff_in = yoff_ff + 8'd1;
            end
         end
         ST_MONTH: begin
            if (days_ff >= {11'd0, mlen}) begin
               days_in = days_ff - {11'd0, mlen};
               if (mon_ff == LastMonth) begin
                  state_in = ST_CHECK;
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cfg.summer_enable && !applied_ff && summer_rule) begin
               ts_in      = ts_ff + SecsPerHour;
               applied_in = 1'b1;
               state_in   = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;
   assign done = state_ff == ST_DONE;

   assign cal.local_seconds    = ts_ff;
   assign cal.second_of_minute = sec_ff;
   assign cal.minute_of_hour   = min_ff;
   assign cal.hour_of_day      = hour_ff;
   assign cal.weekday          = wday_ff;
   assign cal.years_since_1970 = yoff_ff;
   assign cal.month_number     = mon_ff + 4'd1;
   assign cal.day_of_month     = days_ff[4:0] + 5'd1;
   assign cal.summer_applied   = applied_ff;

endmodule

// ===== hdl/epoch_to_local_calendar.sv =====
// Top level of the calendar block: configuration registers, command handshake and
// result strobe. Depends on epc_pkg, epc_core and assert_macros.svh.
//
// An item is taken when start is high and busy is low, and busy stays high until its
// result has been shown. Each breakdown takes a load step, four divisions on the
// shared reciprocal divider, a walk over the years since 1970, a walk over the
// months and a check. When the summer hour is added the breakdown runs a second
// time. The next item can be taken as soon as busy is low.
// The result is on the rsp_ ports for exactly one cycle, marked by rsp_valid, and must
// be captured then; the block cannot be held off.
`include "assert_macros.svh"

module epoch_to_local_calendar
   import epc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [31:0] rsp_local_seconds,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [2:0]  rsp_weekday,
   output logic [7:0]  rsp_years_since_1970,
   output logic [3:0]  rsp_month_number,
   output logic [4:0]  rsp_day_of_month,
   output logic        rsp_summer_applied,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cal_type cal;
   logic    go;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrZoneHours: begin
               cfg_in.zone_hours = csr_wdata;
            end
            CsrSummerEnable: begin
               cfg_in.summer_enable = csr_wdata[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign go = start && !busy;

   epc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .go            (go),
      .epoch_seconds (req_epoch_seconds),
      .busy          (busy),
      .done          (rsp_valid),
      .cal           (cal)
   );

   assign rsp_local_seconds    = cal.local_seconds;
   assign rsp_second_of_minute = cal.second_of_minute;
   assign rsp_minute_of_hour   = cal.minute_of_hour;
   assign rsp_hour_of_day      = cal.hour_of_day;
   assign rsp_weekday          = cal.weekday;
   assign rsp_years_since_1970 = cal.years_since_1970;
   assign rsp_month_number     = cal.month_number;
   assign rsp_day_of_month     = cal.day_of_month;
   assign rsp_summer_applied   = cal.summer_applied;

   `EPC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `EPC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `EPC_ASSERT(a_result_while_busy, clock, reset, !rsp_valid || busy)
   `EPC_ASSERT(a_summer_needs_enable, clock, reset, !(rsp_valid && rsp_summer_applied) || cfg_ff.summer_enable)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for epoch_to_local_calendar: drives timestamps and zone/summer
// settings, predicts each local calendar breakdown and compares every returned item.
// Depends on epc_pkg (cal_type and the register indices) and the RTL of the calendar block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import epc_pkg::cal_type;

   localparam logic CSR_ZONE_HOURS    = epc_pkg::CsrZoneHours;
   localparam logic CSR_SUMMER_ENABLE = epc_pkg::CsrSummerEnable;

   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam int unsigned MARCH         = 3;
   localparam int unsigned OCTOBER       = 10;
   localparam int unsigned SUMMER_DAY    = 25;
   localparam int unsigned DRAIN_SETTLE  = 8;
   localparam int unsigned TAIL_CYCLES   = 600;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned PHASE_ITEMS   = 42;

   localparam logic [4:0] MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                              5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   // Leap days, the 2100 non-leap year, daylight rule edges and both ends of the range.
   localparam logic [31:0] ANCHORS [8] = '{32'd0, 32'd951782400, 32'd4102444800,
                                           32'd4107542400, 32'd1711411200, 32'd1729814400,
                                           32'hFFFF_FFFF, 32'd1704067200};

   typedef enum logic [1:0] {OP_ITEM, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [31:0] epoch;
      logic        csr_idx;
      logic [4:0]  csr_data;
      int unsigned gap;
   } pending_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic [31:0] rsp_local_seconds;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [2:0]  rsp_weekday;
   logic [7:0]  rsp_years_since_1970;
   logic [3:0]  rsp_month_number;
   logic [4:0]  rsp_day_of_month;
   logic        rsp_summer_applied;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_ZONE_HOURS;
   logic [4:0]  csr_wdata = '0;

   pending_op_type pending_ops[$];
   cal_type        expected_calendars[$];
   pending_op_type cur_op;
   logic        op_loaded = 1'b0;
   int unsigned hold_left = 0;
   int unsigned ops_total = 0;
   int unsigned ops_done = 0;
   int unsigned items_issued = 0;
   int unsigned items_taken = 0;
   int unsigned csr_writes_issued = 0;
   int unsigned csr_writes_taken = 0;
   int unsigned stalled_cycles = 0;
   int unsigned mismatches = 0;

   // Shadow copy of the block's configuration registers.
   logic [4:0]  zone_setting = '0;
   logic        summer_setting = 1'b0;

   epoch_to_local_calendar dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_local_seconds    (rsp_local_seconds),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_weekday          (rsp_weekday),
      .rsp_years_since_1970 (rsp_years_since_1970),
      .rsp_month_number     (rsp_month_number),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_summer_applied   (rsp_summer_applied),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic is_leap_year(input int unsigned yoff);
      int unsigned year;
      year = 1970 + yoff;
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic cal_type split_calendar(input logic [31:0] secs);
      cal_type     c;
      logic [31:0] t;
      logic [31:0] days;
      logic [31:0] acc;
      logic [31:0] len;
      int unsigned yoff;
      int unsigned mon;
      c = '0;
      c.local_seconds = secs;
      c.second_of_minute = 6'(secs % 60);
      t = secs / 60;
      c.minute_of_hour = 6'(t % 60);
      t = t / 60;
      c.hour_of_day = 5'(t % 24);
      days = t / 24;
      c.weekday = 3'((days + 4) % 7 + 1);
      yoff = 0;
      acc = 0;
      len = is_leap_year(yoff) ? 366 : 365;
      while (acc + len <= days) begin
         acc += len;
         yoff++;
         len = is_leap_year(yoff) ? 366 : 365;
      end
      days -= acc;
      mon = 0;
      len = MONTH_DAYS[0];
      while (mon < 11 && days >= len) begin
         days -= len;
         mon++;
         len = (mon == 1 && is_leap_year(yoff)) ? 29 : MONTH_DAYS[mon];
      end
      c.years_since_1970 = 8'(yoff);
      c.month_number = 4'(mon + 1);
      c.day_of_month = 5'(days + 1);
      return c;
   endfunction

   function automatic cal_type local_calendar_of(input logic [31:0] epoch);
      cal_type     c;
      logic [31:0] zone_ext;
      logic [31:0] shifted;
      zone_ext = {{27{zone_setting[4]}}, zone_setting};
      shifted = epoch + zone_ext * SECS_PER_HOUR;
      c = split_calendar(shifted);
      if (summer_setting &&
          ((c.month_number > MARCH && c.month_number < OCTOBER) ||
           (c.month_number == MARCH && c.day_of_month > SUMMER_DAY) ||
           (c.month_number == OCTOBER && c.day_of_month < SUMMER_DAY))) begin
         c = split_calendar(shifted + SECS_PER_HOUR);
         c.summer_applied = 1'b1;
      end
      return c;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_item(input logic [31:0] epoch, input int unsigned gap);
      pending_op_type op;
      op = '{OP_ITEM, epoch, CSR_ZONE_HOURS, 5'd0, gap};
      pending_ops.push_back(op);
      ops_total++;
   endtask

   task automatic add_csr(input logic idx, input logic [4:0] data);
      pending_op_type op;
      op = '{OP_CSR, 32'd0, idx, data, 0};
      pending_ops.push_back(op);
      ops_total++;
   endtask

   // Holds the sender until every expected item has returned and the block is idle.
   task automatic add_drain();
      pending_op_type op;
      op = '{OP_DRAIN, 32'd0, CSR_ZONE_HOURS, 5'd0, DRAIN_SETTLE};
      pending_ops.push_back(op);
      ops_total++;
   endtask

   // Driver: all inputs change on the falling edge, each with one assignment per edge.
   always @(negedge clock) begin
      logic nx_start;
      logic nx_csr_valid;
      nx_start = start;
      nx_csr_valid = csr_valid;
      if (!reset) begin
         if (start && items_taken == items_issued) begin
            nx_start = 1'b0;
            ops_done++;
         end
         if (csr_valid && csr_writes_taken == csr_writes_issued) begin
            nx_csr_valid = 1'b0;
            ops_done++;
         end
         if (!nx_start && !nx_csr_valid) begin
            if (!op_loaded && pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               op_loaded = 1'b1;
               hold_left = cur_op.gap;
            end
            if (op_loaded) begin
               case (cur_op.kind)
                  OP_DRAIN: begin
                     if (expected_calendars.size() != 0 || busy) begin
                        hold_left = DRAIN_SETTLE;
                     end else if (hold_left != 0) begin
                        hold_left--;
                     end else begin
                        op_loaded = 1'b0;
                        ops_done++;
                     end
                  end
                  default: begin
                     // Idle cycles are counted while the block is free, so gaps land
                     // between items rather than hiding behind busy.
                     if (hold_left != 0) begin
                        if (!busy) begin
                           hold_left--;
                        end
                     end else if (cur_op.kind == OP_ITEM) begin
                        req_epoch_seconds <= cur_op.epoch;
                        nx_start = 1'b1;
                        items_issued++;
                        op_loaded = 1'b0;
                     end else begin
                        csr_index <= cur_op.csr_idx;
                        csr_wdata <= cur_op.csr_data;
                        nx_csr_valid = 1'b1;
                        csr_writes_issued++;
                        op_loaded = 1'b0;
                     end
                  end
               endcase
            end
         end
      end
      start <= nx_start;
      csr_valid <= nx_csr_valid;
   end

   // Monitor: tracks accepted items and register writes, checks each returned item.
   always @(posedge clock) begin
      cal_type want;
      logic    progress;
      progress = 1'b0;
      if (reset) begin
         zone_setting = '0;
         summer_setting = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ZONE_HOURS) begin
               zone_setting = csr_wdata;
            end else begin
               summer_setting = csr_wdata[0];
            end
            csr_writes_taken <= csr_writes_taken + 1;
            progress = 1'b1;
         end
         if (start && !busy) begin
            expected_calendars.push_back(local_calendar_of(req_epoch_seconds));
            items_taken <= items_taken + 1;
            progress = 1'b1;
         end
         if (rsp_valid) begin
            progress = 1'b1;
            if (expected_calendars.size() == 0) begin
               $error("unexpected result item: local_seconds %0d", rsp_local_seconds);
               mismatches++;
            end else begin
               want = expected_calendars.pop_front();
               check_field("local_seconds", want.local_seconds, rsp_local_seconds);
               check_field("second_of_minute", want.second_of_minute, rsp_second_of_minute);
               check_field("minute_of_hour", want.minute_of_hour, rsp_minute_of_hour);
               check_field("hour_of_day", want.hour_of_day, rsp_hour_of_day);
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("years_since_1970", want.years_since_1970, rsp_years_since_1970);
               check_field("month_number", want.month_number, rsp_month_number);
               check_field("day_of_month", want.day_of_month, rsp_day_of_month);
               check_field("summer_applied", want.summer_applied, rsp_summer_applied);
            end
         end
         stalled_cycles = progress ? 0 : stalled_cycles + 1;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [4:0]  zone;
      logic        summer;
      logic        quiet;
      logic [31:0] epoch;
      int unsigned gap;

      // Reset values: no zone shift, no summer hour.
      add_item(32'd0, 0);
      add_item(32'hFFFF_FFFF, 0);
      add_item(32'd951782400, 0);
      add_item(32'd951868800, 0);
      add_item(32'd4107542399, 0);
      add_item(32'd4107542400, 0);

      // Most negative zone, below the intended range; the sum wraps below zero.
      add_drain();
      add_csr(CSR_ZONE_HOURS, 5'h10);
      add_csr(CSR_SUMMER_ENABLE, 5'h01);
      add_item(32'd0, 0);
      add_item(32'd57599, 0);
      add_item(32'd57600, 0);
      add_item(32'hFFFF_FFFF, 0);

      // Largest positive zone, above the intended range; the sum wraps past 2^32.
      add_drain();
      add_csr(CSR_ZONE_HOURS, 5'h0F);
      add_item(32'd4294913295, 0);
      add_item(32'd4294913296, 0);

      // Edges of the daylight rule at the end of March and in late October.
      add_drain();
      add_csr(CSR_ZONE_HOURS, 5'h00);
      add_item(32'd1711411199, 0);
      add_item(32'd1711411200, 0);
      add_item(32'd1729810799, 0);
      add_item(32'd1729814399, 0);
      add_item(32'd1729814400, 0);

      // Intended extremes of the zone, with the rule off and then on.
      add_drain();
      add_csr(CSR_ZONE_HOURS, 5'h14);
      add_csr(CSR_SUMMER_ENABLE, 5'h00);
      add_item(32'd43199, 0);
      add_item(32'd43200, 0);
      add_item(32'd1711411200, 0);
      add_drain();
      add_csr(CSR_ZONE_HOURS, 5'd14);
      add_csr(CSR_SUMMER_ENABLE, 5'h1F);
      add_item(32'hFFFF_FFFF, 0);
      add_item(32'd4294916895, 0);

      for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: zone = 5'h10;
            1: zone = 5'h0F;
            2: zone = 5'd14;
            3: zone = 5'h14;
            default: zone = 5'($urandom_range(0, 31));
         endcase
         summer = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
         quiet = (ph == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
         add_drain();
         add_csr(CSR_ZONE_HOURS, zone);
         add_csr(CSR_SUMMER_ENABLE, {4'($urandom_range(0, 15)), summer});
         for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
            gap = 0;
            if (!quiet && $urandom_range(0, 2) == 0) begin
               gap = $urandom_range(1, 11);
            end
            if ($urandom_range(0, 9) < 6) begin
               epoch = $urandom;
            end else begin
               epoch = ANCHORS[$urandom_range(0, 7)] + $urandom_range(0, 2 * SECS_PER_DAY)
                       - SECS_PER_DAY;
            end
            add_item(epoch, gap);
         end
      end
      add_drain();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(ops_done == ops_total && expected_calendars.size() == 0)) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/epc_pkg.sv
hdl/epc_div.sv
hdl/epc_core.sv
hdl/epoch_to_local_calendar.sv
verif/tb_top.sv
